// ----- rtl/edf_pkg.sv -----
// Package with item types and status codes for the deadline task queue.
package edf_pkg;

    typedef enum logic [1:0] {
        REQ_CREATE  = 2'd0,
        REQ_OVERDUE = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_TEMPLATE = 3'd1,
        ST_NOT_FOUND    = 3'd2,
        ST_NO_RUNNING   = 3'd3,
        ST_ACTIVE_FULL  = 3'd4,
        ST_OVERDUE_FULL = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  template_index;
        logic [31:0] task_id;
        logic [31:0] now_ticks;
        logic [31:0] deadline_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] affected_id;
        logic        running_valid;
        logic [31:0] running_id;
        logic [31:0] running_deadline;
        logic        running_changed;
    } t_out_item;

endpackage

// ----- rtl/edf_deadline_task_queue_unit.sv -----
// Earliest-deadline-first task queue with active and overdue tables held in memories.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | input     | i_in_valid/o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we           | i_cfg_data (template_count)
//
// One item is handled at a time. A create scans the active table for its place
// and then shifts the tail one entry per cycle. A delete that misses scans both
// tables, which sets the worst case for an item.
// Reset is synchronous and active low; it clears the counts and the control state.
// The memory content is not cleared, since only entries below a count are read.
// While a result waits behind i_out_stall, no new item is accepted.
module edf_deadline_task_queue_unit #(
    parameter int MAX_TASKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  edf_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output edf_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);
    import edf_pkg::*;

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_INS_RD, S_INS_CMP, S_INS_SHIFT,
        S_DEL_RD, S_DEL_CMP, S_OD_RD, S_OD_CMP, S_ASHIFT, S_OSHIFT,
        S_HEAD_RD, S_HEAD, S_OUT
    } t_state;

    // Active entry holds {id, deadline}; overdue entry holds the id.
    logic [63:0] r_amem [MAX_TASKS];
    logic [31:0] r_omem [MAX_TASKS];
    logic [63:0] r_ard;
    logic [31:0] r_ord;
    logic        a_we, o_we;
    logic [AW-1:0] a_wa, a_ra, o_wa, o_ra;
    logic [63:0] a_wd;
    logic [31:0] o_wd;

    always_ff @(posedge i_clk) begin
        if (a_we) r_amem[a_wa] <= a_wd;
        if (o_we) r_omem[o_wa] <= o_wd;
        r_ard <= r_amem[a_ra];
        r_ord <= r_omem[o_ra];
    end

    t_state       r_state;
    t_in_item     r_item;
    logic [7:0]   r_tcount;
    logic [CW-1:0] r_acount, r_ocount, r_pos;
    logic [31:0]  r_dl;
    logic [2:0]   r_status;
    logic [31:0]  r_aff;
    logic         r_changed;
    logic [63:0]  r_hold;
    t_out_item    r_out;
    logic         r_out_valid;

    // The current walk position drives the read address. A delete or overdue shift writes the entry
    // read last cycle and reads the one after next, so the data keeps one step ahead.
    always_comb begin
        a_we = 1'b0; o_we = 1'b0;
        a_wa = r_pos[AW-1:0];
        o_wa = r_pos[AW-1:0];
        a_wd = r_hold;
        o_wd = r_hold[63:32];
        a_ra = r_pos[AW-1:0];
        o_ra = r_pos[AW-1:0];
        unique case (r_state)
            S_IDLE: a_ra = '0;
            S_INS_SHIFT: begin
                a_we = 1'b1;
                a_wa = r_pos[AW-1:0];
                a_wd = r_hold;
                a_ra = AW'(r_pos + CW'(1));
            end
            S_DEL_CMP: a_ra = AW'(r_pos + CW'(1));
            S_OD_CMP: o_ra = AW'(r_pos + CW'(1));
            S_ASHIFT: begin
                a_we = (r_pos + 1'b1) < r_acount;
                a_wa = r_pos[AW-1:0];
                a_wd = r_ard;
                a_ra = AW'(r_pos + CW'(2));
            end
            S_OSHIFT: begin
                o_we = (r_pos + 1'b1) < r_ocount;
                o_wa = r_pos[AW-1:0];
                o_wd = r_ord;
                o_ra = AW'(r_pos + CW'(2));
            end
            S_DECIDE: begin
                o_we = (r_item.req_type == REQ_OVERDUE) && (r_acount != '0)
                       && (r_ocount != FULL) && r_changed;
                o_wa = r_ocount[AW-1:0];
                o_wd = r_ard[63:32];
                a_ra = AW'(1);
            end
            S_HEAD_RD, S_HEAD: a_ra = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acount    <= '0;
            r_ocount    <= '0;
            r_tcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_tcount <= i_cfg_data;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && !r_out_valid) begin
                    r_item    <= i_in_item;
                    r_dl      <= i_in_item.now_ticks + i_in_item.deadline_offset;
                    r_pos     <= '0;
                    r_status  <= ST_OK;
                    r_aff     <= '0;
                    r_changed <= 1'b1;   // marks the head read pending in S_DECIDE
                    r_state   <= S_DECIDE;
                end
                S_DECIDE: begin
                    // r_ard now holds entry 0. Only a successful overdue move
                    // changes the head at this point.
                    r_changed <= (r_item.req_type == REQ_OVERDUE) && (r_acount != '0)
                                 && (r_ocount != FULL);
                    r_pos     <= '0;
                    case (r_item.req_type)
                        REQ_CREATE:
                            if (r_item.template_index >= r_tcount) begin
                                r_status <= ST_BAD_TEMPLATE; r_state <= S_HEAD_RD;
                            end else if (r_acount == FULL) begin
                                r_status <= ST_ACTIVE_FULL; r_state <= S_HEAD_RD;
                            end else begin
                                r_aff   <= r_item.task_id;
                                r_hold  <= {r_item.task_id, r_dl};
                                r_state <= S_INS_RD;
                            end
                        REQ_OVERDUE:
                            if (r_acount == '0) begin
                                r_status <= ST_NO_RUNNING; r_state <= S_HEAD_RD;
                            end else if (r_ocount == FULL) begin
                                r_status <= ST_OVERDUE_FULL; r_state <= S_HEAD_RD;
                            end else begin
                                r_aff     <= r_ard[63:32];
                                r_ocount  <= r_ocount + 1'b1;
                                r_state   <= S_ASHIFT;
                            end
                        REQ_DELETE: r_state <= S_DEL_RD;
                        default: begin
                            if (r_acount == '0) r_status <= ST_NO_RUNNING;
                            r_state <= S_HEAD_RD;
                        end
                    endcase
                end
                S_INS_RD: r_state <= S_INS_CMP;
                S_INS_CMP:
                    // Insert before the first entry with a later deadline, else at the end.
                    if (r_pos == r_acount || r_dl < r_ard[31:0]) begin
                        if (r_pos == '0) r_changed <= 1'b1;
                        r_acount <= r_acount + 1'b1;
                        r_state  <= S_INS_SHIFT;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_INS_RD;
                    end
                S_INS_SHIFT: begin
                    // Write the held entry here, then carry the displaced one forward.
                    r_hold <= r_ard;
                    if (r_pos + 1'b1 >= r_acount) begin
                        r_state <= S_HEAD_RD;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_DEL_RD: r_state <= (r_pos == r_acount) ? S_OD_RD : S_DEL_CMP;
                S_DEL_CMP:
                    if (r_ard[63:32] == r_item.task_id) begin
                        if (r_pos == '0) r_changed <= 1'b1;
                        r_aff   <= r_item.task_id;
                        r_state <= S_ASHIFT;
                    end else if (r_pos + 1'b1 == r_acount) begin
                        r_pos   <= '0;
                        r_state <= S_OD_RD;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_DEL_RD;
                    end
                S_OD_RD:
                    if (r_pos == r_ocount) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_HEAD_RD;
                    end else begin
                        r_state <= S_OD_CMP;
                    end
                S_OD_CMP:
                    if (r_ord == r_item.task_id) begin
                        r_aff   <= r_item.task_id;
                        r_state <= S_OSHIFT;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_OD_RD;
                    end
                S_ASHIFT:
                    // Read of pos+2 lands next cycle; the write uses the last read.
                    if (r_pos + 1'b1 >= r_acount) begin
                        r_acount <= r_acount - 1'b1;
                        r_state  <= S_HEAD_RD;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                S_OSHIFT:
                    if (r_pos + 1'b1 >= r_ocount) begin
                        r_ocount <= r_ocount - 1'b1;
                        r_state  <= S_HEAD_RD;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                S_HEAD_RD: r_state <= S_HEAD;
                S_HEAD: r_state <= S_OUT;
                S_OUT: begin
                    r_out.status           <= r_status;
                    r_out.affected_id      <= r_aff;
                    r_out.running_valid    <= r_acount != '0;
                    r_out.running_id       <= (r_acount != '0) ? r_ard[63:32] : '0;
                    r_out.running_deadline <= (r_acount != '0) ? r_ard[31:0] : '0;
                    r_out.running_changed  <= r_changed;
                    r_out_valid            <= 1'b1;
                    r_state                <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_acount_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acount <= FULL) else $error("active count beyond depth");
    a_ocount_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= FULL) else $error("overdue count beyond depth");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("accepting while busy");
    a_out_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT)) else $error("stray result");
`endif

endmodule

// ----- tb/sv/edf_deadline_task_queue_unit_tb.sv -----
// Self-checking testbench for the earliest-deadline-first task queue unit.
module edf_deadline_task_queue_unit_tb;

    import edf_pkg::*;

    localparam int TASK_SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // The scoreboard keeps its own copy of both tables. Every accepted item is
    // applied to that copy, and the result it must produce is queued in order.
    class edf_scoreboard;
        logic [31:0] act_id[$];
        logic [31:0] act_dl[$];
        logic [31:0] late_id[$];
        logic [7:0]  tmpl_limit;
        t_out_item   pending_results[$];
        int          errors;
        int          checked;
        int          head_moves;

        function void clear();
            act_id.delete();
            act_dl.delete();
            late_id.delete();
            tmpl_limit = 8'd0;
            pending_results.delete();
            errors = 0;
            checked = 0;
            head_moves = 0;
        endfunction

        // Apply one accepted request to the tables and queue its result.
        function void note_request(t_in_item req);
            t_out_item   res;
            logic [31:0] dl;
            int          pos;
            bit          hit;
            res = '0;
            res.status = ST_OK;
            case (t_req'(req.req_type))
                REQ_CREATE: begin
                    if (req.template_index >= tmpl_limit) begin
                        res.status = ST_BAD_TEMPLATE;
                    end else if (act_id.size() >= TASK_SLOTS) begin
                        res.status = ST_ACTIVE_FULL;
                    end else begin
                        // Equal deadlines keep their arrival order.
                        dl = req.now_ticks + req.deadline_offset;
                        pos = 0;
                        while (pos < act_dl.size() && !(dl < act_dl[pos])) pos++;
                        act_id.insert(pos, req.task_id);
                        act_dl.insert(pos, dl);
                        res.affected_id = req.task_id;
                        res.running_changed = (pos == 0);
                    end
                end
                REQ_OVERDUE: begin
                    if (act_id.size() == 0) begin
                        res.status = ST_NO_RUNNING;
                    end else if (late_id.size() >= TASK_SLOTS) begin
                        res.status = ST_OVERDUE_FULL;
                    end else begin
                        res.affected_id = act_id[0];
                        late_id.push_back(act_id[0]);
                        void'(act_id.pop_front());
                        void'(act_dl.pop_front());
                        res.running_changed = 1'b1;
                    end
                end
                REQ_DELETE: begin
                    // The active table is searched first, then the overdue one.
                    hit = 0;
                    for (int i = 0; i < act_id.size(); i++) begin
                        if (act_id[i] == req.task_id) begin
                            hit = 1;
                            res.running_changed = (i == 0);
                            act_id.delete(i);
                            act_dl.delete(i);
                            break;
                        end
                    end
                    if (!hit) begin
                        for (int i = 0; i < late_id.size(); i++) begin
                            if (late_id[i] == req.task_id) begin
                                hit = 1;
                                late_id.delete(i);
                                break;
                            end
                        end
                    end
                    if (hit) res.affected_id = req.task_id;
                    else res.status = ST_NOT_FOUND;
                end
                default: begin
                    if (act_id.size() == 0) res.status = ST_NO_RUNNING;
                end
            endcase
            if (act_id.size() > 0) begin
                res.running_valid = 1'b1;
                res.running_id = act_id[0];
                res.running_deadline = act_dl[0];
            end
            if (res.running_changed) head_moves++;
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest queued expectation.
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.affected_id !== want.affected_id) begin
                $error("affected_id expected %h actual %h", want.affected_id, got.affected_id);
                errors++;
            end
            if (got.running_valid !== want.running_valid) begin
                $error("running_valid expected %b actual %b",
                       want.running_valid, got.running_valid);
                errors++;
            end
            if (got.running_id !== want.running_id) begin
                $error("running_id expected %h actual %h", want.running_id, got.running_id);
                errors++;
            end
            if (got.running_deadline !== want.running_deadline) begin
                $error("running_deadline expected %h actual %h",
                       want.running_deadline, got.running_deadline);
                errors++;
            end
            if (got.running_changed !== want.running_changed) begin
                $error("running_changed expected %b actual %b",
                       want.running_changed, got.running_changed);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic [7:0] i_cfg_data;

    edf_deadline_task_queue_unit #(.MAX_TASKS(TASK_SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    edf_scoreboard sched_model;

    // Idle percentages of the sender and of the receiver for the current phase.
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;

    // Recently used ids, so that deletes and duplicates hit existing tasks.
    logic [31:0] recent_ids[$];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver: stall at random, and check every item taken from the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) sched_model.check_result(o_out_item);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("edf_deadline_task_queue_unit test failed");
                $finish;
            end
        end
    end

    // Offer one item, waiting out random sender gaps, until the block takes it.
    // Valid stays high after the accepting edge until the next call drives the
    // following item or a gap in the same time step.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sched_model.note_request(req);
    endtask

    task automatic send_fields(input t_req kind, input logic [7:0] tmpl,
                               input logic [31:0] id, input logic [31:0] now,
                               input logic [31:0] offs);
        t_in_item req;
        req.req_type = kind;
        req.template_index = tmpl;
        req.task_id = id;
        req.now_ticks = now;
        req.deadline_offset = offs;
        send_request(req);
    endtask

    // Let every result drain, then wait for the block to settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sched_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * TASK_SLOTS + 10) @(posedge i_clk);
    endtask

    // Register writes happen only while nothing is in flight.
    task automatic write_template_count(input logic [7:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sched_model.tmpl_limit = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_id();
        if (recent_ids.size() > 0 && $urandom_range(3) != 0)
            return recent_ids[$urandom_range(recent_ids.size() - 1)];
        return $urandom();
    endfunction

    // Random traffic: mostly creates and deletes of known ids, so that both
    // tables fill, overflow and drain again. Deadlines are often close together
    // so that ties and near-wrap sums come up.
    task automatic random_traffic(input int count);
        t_in_item    req;
        logic [31:0] id;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            id = pick_id();
            req.task_id = id;
            req.template_index = $urandom_range(99) < 85 ?
                8'($urandom_range(sched_model.tmpl_limit > 0 ? sched_model.tmpl_limit - 1 : 0))
                : 8'($urandom());
            req.now_ticks = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(40));
            req.deadline_offset = $urandom_range(3) == 0 ? $urandom() :
                                  32'($urandom_range(40));
            if (pick < 40) begin
                req.req_type = REQ_CREATE;
                req.task_id = $urandom_range(3) == 0 ? id : $urandom();
                recent_ids.push_back(req.task_id);
                if (recent_ids.size() > 40) void'(recent_ids.pop_front());
            end else if (pick < 60) begin
                req.req_type = REQ_OVERDUE;
            end else if (pick < 88) begin
                req.req_type = REQ_DELETE;
            end else begin
                req.req_type = REQ_QUERY;
            end
            send_request(req);
        end
    endtask

    initial begin
        sched_model = new();
        sched_model.clear();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no templates every create is rejected, and an
        // empty table answers queries and overdue moves with no running task.
        send_fields(REQ_CREATE, 8'd0, 32'h1, 32'h0, 32'h0);
        send_fields(REQ_QUERY, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_OVERDUE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_DELETE, 8'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        write_template_count(8'd255);
        send_fields(REQ_CREATE, 8'd255, 32'h5, 32'h0, 32'h0);
        send_fields(REQ_CREATE, 8'd254, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
        send_fields(REQ_CREATE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_CREATE, 8'd1, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_CREATE, 8'd2, 32'hAAAA_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(REQ_QUERY, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_DELETE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_OVERDUE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_DELETE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_DELETE, 8'd0, 32'h1234, 32'h0, 32'h0);
        // Fill the active table past its size, then the overdue table.
        for (int k = 0; k < TASK_SLOTS + 1; k++)
            send_fields(REQ_CREATE, 8'd3, 32'(100 + k), 32'h10, 32'(TASK_SLOTS - k));
        for (int k = 0; k < TASK_SLOTS + 1; k++)
            send_fields(REQ_OVERDUE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_CREATE, 8'd0, 32'h77, 32'h0, 32'h1);
        send_fields(REQ_OVERDUE, 8'd0, 32'h0, 32'h0, 32'h0);
        send_fields(REQ_DELETE, 8'd0, 32'(100 + TASK_SLOTS), 32'h0, 32'h0);

        // Random part in four phases, with a new template count in each.
        write_template_count(8'd1);
        send_idle_pct = 21;
        recv_idle_pct = 67;
        random_traffic(280);
        write_template_count(8'($urandom_range(2, 254)));
        send_idle_pct = 67;
        recv_idle_pct = 21;
        random_traffic(280);
        write_template_count(8'd0);
        random_traffic(20);
        write_template_count(8'd128);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(270);

        wait_drained();
        $display("Checked %0d results over %0d template settings;",
                 sched_model.checked, 5);
        $display("the running task moved %0d times.", sched_model.head_moves);
        if (sched_model.errors == 0) begin
            $display("edf_deadline_task_queue_unit test passed");
        end else begin
            $display("edf_deadline_task_queue_unit test failed");
        end
        $finish;
    end

endmodule
